// ----- sv/point_plane_reflection_assert.svh -----
`ifndef POINT_PLANE_REFLECTION_ASSERT_SVH
`define POINT_PLANE_REFLECTION_ASSERT_SVH
// assertion macros for the plane reflection checker

// same-cycle implication, held off during reset
`define PPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define PPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, live through reset
`define PPR_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ppr_pkg.sv -----
// shared types and constants of the plane reflection pipeline
`timescale 1ns / 1ps
`default_nettype none

package ppr_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 32;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int PART_W     = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 2;
    localparam int MAG_W      = PROD_W;
    localparam int NUM_W      = 3 * COORD_W;
    localparam int REM_W      = PROD_W;
    // quotients at or above 2**QUO_BITS always clamp the coordinate
    localparam int QUO_BITS   = COORD_W + 2;
    localparam int RES_W      = QUO_BITS + 2;
    localparam int TDATA_W    = 3 * COORD_W;
    localparam int TUSER_W    = 2;
    localparam int TUSER_BAD  = 0;
    localparam int TUSER_SAT  = 1;
    localparam int REG_IDX_W  = 2;

    localparam int DOT_STAGES = 4;
    localparam int SCL_STAGES = 3;
    localparam int OUT_STAGES = 1;
    localparam int PIPE_DEPTH = DOT_STAGES + SCL_STAGES + QUO_BITS + OUT_STAGES;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef coord_t [2:0] vec3_t;

    localparam coord_t A_RESET = COORD_W'(1) << FRAC_BITS;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PLANE_A      = 2'd0,
        REG_PLANE_B      = 2'd1,
        REG_PLANE_C      = 2'd2,
        REG_PLANE_OFFSET = 2'd3
    } reg_idx_t;

    typedef struct packed {
        vec3_t  coef;
        coord_t offset;
    } plane_t;

    // plane distance numerator, as magnitude and sign
    typedef struct packed {
        logic             vld;
        vec3_t            pt;
        logic [MAG_W-1:0] s_mag;
        logic             s_neg;
    } dot_t;

    // per-axis long division state
    typedef struct packed {
        logic                      vld;
        vec3_t                     pt;
        logic [2:0]                neg;
        logic [2:0]                ovf;
        logic [2:0][REM_W-1:0]     rem;
        logic [2:0][QUO_BITS-1:0]  low;
        logic [2:0][QUO_BITS-1:0]  quo;
    } div_t;

    typedef struct packed {
        logic  vld;
        vec3_t pt;
        logic  bad;
        logic  sat;
    } res_t;

endpackage

`default_nettype wire

// ----- sv/point_plane_reflection.sv -----
// top level of the point reflection across a configured plane
`timescale 1ns / 1ps
`default_nettype none

// Mirrors each streamed 3D point (signed Q16.16) across the plane
// a*x + b*y + c*z + d = 0 held in four configuration registers. The plane
// distance numerator is formed exactly, scaled by twice each normal
// coefficient and divided by a*a + b*b + c*c with the quotient truncated
// toward zero; results clamp to 32 bits and raise the saturated flag.
// When a, b and c are all zero the point comes back unchanged with
// bad_plane set. One point is taken per clock unless the output stalls and
// every stage is full. 4 stages form the numerator, 3 stages scale it,
// 34 stages of the restoring divider produce one quotient bit each, and
// the output register holds the result. Each stage loads when it is empty
// or its successor moves, so bubbles are squeezed out and input transfers
// continue while a result waits, until all stages are full. Plane writes
// are taken in any cycle and pass through the sq_reg and norm_reg registers
// into the squared length; write them only while no point is in flight.

module point_plane_reflection (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input points
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ppr_pkg::TDATA_W-1:0]      s_tdata,   // point_x, point_y, point_z
    // reflected points
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ppr_pkg::TDATA_W-1:0]      m_tdata,   // mirror_x, mirror_y, mirror_z
    output logic [ppr_pkg::TUSER_W-1:0]      m_tuser,   // bad_plane, saturated
    // plane register writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ppr_pkg::REG_IDX_W-1:0]    cfg_addr,
    input  logic [ppr_pkg::COORD_W-1:0]      cfg_data
);
    import ppr_pkg::*;

    plane_t            plane_reg;
    vec3_t             in_pt;
    logic              bad_plane;
    dot_t              dot_bus;
    div_t              scl_bus;
    div_t              div_bus;
    res_t              res_bus;
    logic [REM_W-1:0]  norm;
    logic              scl_rdy, div_rdy, out_rdy;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg         <= '0;
            plane_reg.coef[0] <= A_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_PLANE_A:      plane_reg.coef[0] <= cfg_data;
                REG_PLANE_B:      plane_reg.coef[1] <= cfg_data;
                REG_PLANE_C:      plane_reg.coef[2] <= cfg_data;
                REG_PLANE_OFFSET: plane_reg.offset  <= cfg_data;
            endcase
        end
    end

    // normal of zero length, checked straight from the registers
    assign bad_plane = (plane_reg.coef == '0);

    // x in the lowest bits of the transfer
    assign in_pt = s_tdata;

    // numerator: products, two adder levels, magnitude
    ppr_dot u_dot (
        .aclk    (aclk),
        .aresetn (aresetn),
        .plane   (plane_reg),
        .in_vld  (s_tvalid),
        .in_pt   (in_pt),
        .in_rdy  (s_tready),
        .dot_out (dot_bus),
        .out_rdy (scl_rdy)
    );

    // per-axis scaling and divider set-up
    ppr_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .plane   (plane_reg),
        .dot_in  (dot_bus),
        .in_rdy  (scl_rdy),
        .div_out (scl_bus),
        .norm    (norm),
        .out_rdy (div_rdy)
    );

    // quotient, one bit per stage
    ppr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .norm    (norm),
        .div_in  (scl_bus),
        .in_rdy  (div_rdy),
        .div_out (div_bus),
        .out_rdy (out_rdy)
    );

    // subtract, clamp, hold for the master side
    ppr_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .div_in    (div_bus),
        .bad_plane (bad_plane),
        .in_rdy    (out_rdy),
        .res_out   (res_bus),
        .out_rdy   (m_tready)
    );

    assign m_tvalid           = res_bus.vld;
    assign m_tdata            = res_bus.pt;
    assign m_tuser[TUSER_BAD] = res_bus.bad;
    assign m_tuser[TUSER_SAT] = res_bus.sat;

endmodule

`default_nettype wire

// ----- sv/ppr_dot.sv -----
// products, sums and magnitude of the plane distance numerator
`timescale 1ns / 1ps
`default_nettype none

module ppr_dot (
    input  logic            aclk,
    input  logic            aresetn,
    input  ppr_pkg::plane_t plane,
    input  logic            in_vld,
    input  ppr_pkg::vec3_t  in_pt,
    output logic            in_rdy,
    output ppr_pkg::dot_t   dot_out,
    input  logic            out_rdy
);
    import ppr_pkg::*;

    logic                     vld1_reg, vld2_reg, vld3_reg;
    vec3_t                    pt1_reg, pt2_reg, pt3_reg;
    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [PROD_W-1:0] prod_next [3];
    logic signed [PART_W-1:0] part_reg [2];
    logic signed [PART_W-1:0] part_next [2];
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    dot_t                     dot_reg, dot_next;
    logic                     en1, en2, en3, en4;

    // a stage loads when empty or when the next one moves
    assign en4    = !dot_reg.vld || out_rdy;
    assign en3    = !vld3_reg || en4;
    assign en2    = !vld2_reg || en3;
    assign en1    = !vld1_reg || en2;
    assign in_rdy = en1;
    assign dot_out = dot_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod_next[k] = $signed(plane.coef[k]) * $signed(in_pt[k]);
        end
        part_next[0] = PART_W'(prod_reg[0]) + PART_W'(prod_reg[1]);
        part_next[1] = PART_W'(prod_reg[2]) + (PART_W'($signed(plane.offset)) <<< FRAC_BITS);
        sum_next     = SUM_W'(part_reg[0]) + SUM_W'(part_reg[1]);
        dot_next.vld   = vld3_reg;
        dot_next.pt    = pt3_reg;
        dot_next.s_neg = sum_reg[SUM_W-1];
        dot_next.s_mag = sum_reg[SUM_W-1] ? MAG_W'(-sum_reg) : MAG_W'(sum_reg);
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            vld1_reg <= in_vld;
            pt1_reg  <= in_pt;
            prod_reg <= prod_next;
        end
        if (en2) begin
            vld2_reg <= vld1_reg;
            pt2_reg  <= pt1_reg;
            part_reg <= part_next;
        end
        if (en3) begin
            vld3_reg <= vld2_reg;
            pt3_reg  <= pt2_reg;
            sum_reg  <= sum_next;
        end
        if (en4) begin
            dot_reg <= dot_next;
        end
        if (!aresetn) begin
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            vld3_reg    <= 1'b0;
            dot_reg.vld <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- sv/ppr_scale.sv -----
// numerator scaling per axis, squared normal length and division set-up
`timescale 1ns / 1ps
`default_nettype none

module ppr_scale (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ppr_pkg::plane_t           plane,
    input  ppr_pkg::dot_t             dot_in,
    output logic                      in_rdy,
    output ppr_pkg::div_t             div_out,
    output logic [ppr_pkg::REM_W-1:0] norm,
    input  logic                      out_rdy
);
    import ppr_pkg::*;

    logic [COORD_W-1:0]       cmag [3];
    logic                     vld5_reg, vld6_reg;
    vec3_t                    pt5_reg, pt6_reg;
    logic [2:0]               neg5_reg, neg5_next, neg6_reg;
    logic [PROD_W-1:0]        pp_lo_reg [3];
    logic [PROD_W-1:0]        pp_lo_next [3];
    logic [PROD_W-1:0]        pp_hi_reg [3];
    logic [PROD_W-1:0]        pp_hi_next [3];
    logic [NUM_W-1:0]         num_reg [3];
    logic [NUM_W-1:0]         num_next [3];
    logic signed [PROD_W-1:0] sq_next [3];
    logic [PROD_W-1:0]        sq_reg [3];
    logic [REM_W-1:0]         norm_reg, norm_next;
    div_t                     dv_reg, dv_next;
    logic                     en5, en6, en7;

    assign en7     = !dv_reg.vld || out_rdy;
    assign en6     = !vld6_reg || en7;
    assign en5     = !vld5_reg || en6;
    assign in_rdy  = en5;
    assign div_out = dv_reg;
    assign norm    = norm_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cmag[k] = plane.coef[k][COORD_W-1] ? COORD_W'(-$signed(plane.coef[k]))
                                               : COORD_W'(plane.coef[k]);
            neg5_next[k]  = dot_in.s_neg ^ plane.coef[k][COORD_W-1];
            pp_lo_next[k] = PROD_W'(dot_in.s_mag[COORD_W-1:0]) * PROD_W'(cmag[k]);
            pp_hi_next[k] = PROD_W'(dot_in.s_mag[MAG_W-1:COORD_W]) * PROD_W'(cmag[k]);
            // doubled product of magnitude and coefficient
            num_next[k]   = ((NUM_W'(pp_hi_reg[k]) << COORD_W) + NUM_W'(pp_lo_reg[k])) << 1;
            sq_next[k]    = $signed(plane.coef[k]) * $signed(plane.coef[k]);
        end
        norm_next = sq_reg[0] + sq_reg[1] + sq_reg[2];

        dv_next.vld = vld6_reg;
        dv_next.pt  = pt6_reg;
        dv_next.neg = neg6_reg;
        for (int k = 0; k < 3; k++) begin
            // upper part already at or above the divisor means a huge quotient
            dv_next.ovf[k] = REM_W'(num_reg[k][NUM_W-1:QUO_BITS]) >= norm_reg;
            dv_next.rem[k] = REM_W'(num_reg[k][NUM_W-1:QUO_BITS]);
            dv_next.low[k] = num_reg[k][QUO_BITS-1:0];
            dv_next.quo[k] = '0;
        end
    end

    // plane-derived terms follow the registers every cycle
    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            sq_reg[k] <= sq_next[k];
        end
        norm_reg <= norm_next;
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            vld5_reg  <= dot_in.vld;
            pt5_reg   <= dot_in.pt;
            neg5_reg  <= neg5_next;
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
        end
        if (en6) begin
            vld6_reg <= vld5_reg;
            pt6_reg  <= pt5_reg;
            neg6_reg <= neg5_reg;
            num_reg  <= num_next;
        end
        if (en7) begin
            dv_reg <= dv_next;
        end
        if (!aresetn) begin
            vld5_reg   <= 1'b0;
            vld6_reg   <= 1'b0;
            dv_reg.vld <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- sv/ppr_div.sv -----
// pipelined restoring divider, one quotient bit per stage on three lanes
`timescale 1ns / 1ps
`default_nettype none

module ppr_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [ppr_pkg::REM_W-1:0] norm,
    input  ppr_pkg::div_t             div_in,
    output logic                      in_rdy,
    output ppr_pkg::div_t             div_out,
    input  logic                      out_rdy
);
    import ppr_pkg::*;

    div_t stg_reg  [QUO_BITS];
    div_t stg_src  [QUO_BITS];
    div_t stg_next [QUO_BITS];
    logic stg_en   [QUO_BITS+1];

    assign stg_en[QUO_BITS] = out_rdy;
    assign in_rdy           = stg_en[0];
    assign div_out          = stg_reg[QUO_BITS-1];

    for (genvar j = 0; j < QUO_BITS; j++) begin : g_stage
        logic [2:0][REM_W:0] trial;

        if (j == 0) begin : g_first
            assign stg_src[j] = div_in;
        end else begin : g_rest
            assign stg_src[j] = stg_reg[j-1];
        end

        assign stg_en[j] = !stg_reg[j].vld || stg_en[j+1];

        always_comb begin
            stg_next[j] = stg_src[j];
            for (int k = 0; k < 3; k++) begin
                // bring down the next numerator bit
                trial[k] = {stg_src[j].rem[k], stg_src[j].low[k][QUO_BITS-1]};
                if (trial[k] >= {1'b0, norm}) begin
                    stg_next[j].rem[k] = REM_W'(trial[k] - {1'b0, norm});
                    stg_next[j].quo[k] = {stg_src[j].quo[k][QUO_BITS-2:0], 1'b1};
                end else begin
                    stg_next[j].rem[k] = trial[k][REM_W-1:0];
                    stg_next[j].quo[k] = {stg_src[j].quo[k][QUO_BITS-2:0], 1'b0};
                end
                stg_next[j].low[k] = {stg_src[j].low[k][QUO_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (stg_en[j]) begin
                stg_reg[j] <= stg_next[j];
            end
            if (!aresetn) begin
                stg_reg[j].vld <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/ppr_out.sv -----
// subtraction from the point, clamping and output register
`timescale 1ns / 1ps
`default_nettype none

module ppr_out (
    input  logic          aclk,
    input  logic          aresetn,
    input  ppr_pkg::div_t div_in,
    input  logic          bad_plane,
    output logic          in_rdy,
    output ppr_pkg::res_t res_out,
    input  logic          out_rdy
);
    import ppr_pkg::*;

    localparam logic signed [RES_W-1:0] QUO_CAP = RES_W'(1) << QUO_BITS;
    localparam logic signed [RES_W-1:0] POS_LIM = (RES_W'(1) << (COORD_W-1)) - RES_W'(1);
    localparam logic signed [RES_W-1:0] NEG_LIM = ~POS_LIM;

    logic signed [RES_W-1:0] mag  [3];
    logic signed [RES_W-1:0] diff [3];
    logic [2:0]              clip;
    res_t                    res_reg, res_next;
    logic                    en;

    assign en      = !res_reg.vld || out_rdy;
    assign in_rdy  = en;
    assign res_out = res_reg;

    always_comb begin
        res_next.vld = div_in.vld;
        res_next.bad = bad_plane;
        for (int k = 0; k < 3; k++) begin
            mag[k]  = div_in.ovf[k] ? QUO_CAP : $signed(RES_W'(div_in.quo[k]));
            diff[k] = RES_W'($signed(div_in.pt[k])) + (div_in.neg[k] ? mag[k] : -mag[k]);
            clip[k] = 1'b0;
            if (bad_plane) begin
                // degenerate plane passes the point through
                res_next.pt[k] = div_in.pt[k];
            end else if (diff[k] > POS_LIM) begin
                res_next.pt[k] = POS_LIM[COORD_W-1:0];
                clip[k]        = 1'b1;
            end else if (diff[k] < NEG_LIM) begin
                res_next.pt[k] = NEG_LIM[COORD_W-1:0];
                clip[k]        = 1'b1;
            end else begin
                res_next.pt[k] = diff[k][COORD_W-1:0];
            end
        end
        res_next.sat = |clip;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
        if (!aresetn) begin
            res_reg.vld <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- sv/ppr_chk.sv -----
// port-level checker of the plane reflection block and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "point_plane_reflection_assert.svh"

module ppr_chk (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [ppr_pkg::TDATA_W-1:0]   m_tdata,
    input wire logic [ppr_pkg::TUSER_W-1:0]   m_tuser
);
    import ppr_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic [CNT_W-1:0] inflight_reg, inflight_next;

    // points taken but not yet delivered
    always_comb begin
        inflight_next = inflight_reg;
        if (s_tvalid && s_tready) begin
            inflight_next = inflight_next + CNT_W'(1);
        end
        if (m_tvalid && m_tready) begin
            inflight_next = inflight_next - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    `PPR_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `PPR_ASSERT_NOW(a_no_extra, m_tvalid, inflight_reg != '0, "result with no pending point")
    `PPR_ASSERT_NOW(a_depth, 1'b1, inflight_reg <= CNT_W'(PIPE_DEPTH), "more points in flight than stages")
    `PPR_ASSERT_NOW(a_flags, m_tvalid && m_tuser[TUSER_BAD], !m_tuser[TUSER_SAT], "clamp flagged on degenerate plane")
    `PPR_ASSERT_RST(a_rst_rdy, !aresetn, s_tready, "input not ready after reset")

endmodule

bind point_plane_reflection ppr_chk u_ppr_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- tb/tb_point_plane_reflection.sv -----
// self-checking testbench for the point reflection across a configured plane
`timescale 1ns / 1ps

module tb_point_plane_reflection;
    import ppr_pkg::*;

    localparam coord_t ONE  = 32'sd65536;
    localparam coord_t CMAX = 32'sh7FFFFFFF;
    localparam coord_t CMIN = 32'sh80000000;
    localparam int     PHASES     = 12;
    localparam int     PHASE_PTS  = 170;
    localparam int     NUM_ROWS   = 28;

    // one reflected point as it leaves the block
    typedef struct packed {
        vec3_t pt;
        logic  bad_plane;
        logic  saturated;
    } reflection_t;

    typedef enum logic {ROW_POINT, ROW_WRITE} row_kind_e;

    typedef enum logic [2:0] {
        PLANE_AXIS, PLANE_SMALL, PLANE_FULL, PLANE_EXTREME, PLANE_DEGENERATE, PLANE_TINY
    } plane_kind_e;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    // directed row: a point (x, y, z) or a register write (x carries the data);
    // typed rows carry their result, the others go through the predictor
    typedef struct {
        row_kind_e kind;
        reg_idx_t  reg_sel;
        coord_t    x, y, z;
        bit        typed;
        coord_t    ex, ey, ez;
        bit        ebad, esat;
    } stim_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata   = '0;   // point_x, point_y, point_z
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;          // mirror_x, mirror_y, mirror_z
    logic [TUSER_W-1:0]   m_tuser;          // bad_plane, saturated
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [REG_IDX_W-1:0] cfg_addr  = REG_PLANE_A;
    logic [COORD_W-1:0]   cfg_data  = '0;

    reflection_t pending_mirrors[$];
    plane_t      model_plane;
    int          mismatches     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    // directed part: reset plane x = 0 first, then the degenerate plane,
    // then extreme coefficients and offsets, then the smallest normal
    stim_row_t dir_rows [NUM_ROWS] = '{
        '{ROW_POINT, REG_PLANE_A, 0, 0, 0, 1, 0, 0, 0, 0, 0},
        '{ROW_POINT, REG_PLANE_A, ONE, 2*ONE, -3*ONE, 1, -ONE, 2*ONE, -3*ONE, 0, 0},
        '{ROW_POINT, REG_PLANE_A, -1, 0, 0, 1, 1, 0, 0, 0, 0},
        '{ROW_POINT, REG_PLANE_A, CMAX, CMIN, CMAX, 1, -CMAX, CMIN, CMAX, 0, 0},
        '{ROW_POINT, REG_PLANE_A, CMIN, CMAX, CMIN, 1, CMAX, CMAX, CMIN, 0, 1},
        '{ROW_WRITE, REG_PLANE_A, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_POINT, REG_PLANE_A, CMIN, CMAX, 123, 1, CMIN, CMAX, 123, 1, 0},
        '{ROW_WRITE, REG_PLANE_OFFSET, CMAX, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_POINT, REG_PLANE_A, CMAX, -1, CMIN, 1, CMAX, -1, CMIN, 1, 0},
        '{ROW_WRITE, REG_PLANE_B, ONE, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_POINT, REG_PLANE_A, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_POINT, REG_PLANE_A, CMIN, CMIN, CMIN, 0, 0, 0, 0, 0, 0},
        '{ROW_POINT, REG_PLANE_A, CMAX, CMAX, CMAX, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_PLANE_A, CMAX, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_PLANE_B, CMIN, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_PLANE_C, CMIN, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_POINT, REG_PLANE_A, CMAX, CMAX, CMAX, 0, 0, 0, 0, 0, 0},
        '{ROW_POINT, REG_PLANE_A, CMIN, CMIN, CMIN, 0, 0, 0, 0, 0, 0},
        '{ROW_POINT, REG_PLANE_A, 1, -1, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_PLANE_A, CMIN, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_PLANE_OFFSET, CMIN, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_POINT, REG_PLANE_A, CMAX, 0, CMIN, 0, 0, 0, 0, 0, 0},
        '{ROW_POINT, REG_PLANE_A, ONE, ONE, ONE, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_PLANE_A, 1, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_PLANE_B, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_PLANE_C, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_PLANE_OFFSET, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_POINT, REG_PLANE_A, 1000, 5, -7, 1, -1000, 5, -7, 0, 0}
    };

    point_plane_reflection DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mirror of one point: exact numerator, 128-bit quotient truncated toward
    // zero, quotient magnitude capped at 2^62, result clamped to 32 bits
    function automatic reflection_t reflect_point(input plane_t pl, input vec3_t pt);
        logic signed [67:0]  dot, norm_sq, k, p;
        logic        [67:0]  dot_mag;
        logic        [32:0]  cmag;
        logic        [127:0] num, quo;
        logic signed [65:0]  pin, term, res;
        logic                dot_neg;
        reflection_t         r;
        r = '0;
        // degenerate normal: point passes through with the error flag
        if (pl.coef == '0) begin
            r.pt = pt;
            r.bad_plane = 1'b1;
            return r;
        end
        dot = '0;
        norm_sq = '0;
        for (int i = 0; i < 3; i++) begin
            k = $signed(pl.coef[i]);
            p = $signed(pt[i]);
            dot = dot + k * p;
            norm_sq = norm_sq + k * k;
        end
        k = $signed(pl.offset);
        dot = dot + (k <<< FRAC_BITS);
        dot_neg = dot < 0;
        dot_mag = dot_neg ? -dot : dot;
        for (int i = 0; i < 3; i++) begin
            k = $signed(pl.coef[i]);
            cmag = (k < 0) ? -k : k;
            num = dot_mag;
            num = (num * cmag) << 1;
            quo = num / norm_sq[63:0];
            if (quo > (128'd1 << 62))
                quo = 128'd1 << 62;
            term = $signed({2'b00, quo[63:0]});
            if (dot_neg != (k < 0))
                term = -term;
            pin = $signed(pt[i]);
            res = pin - term;
            if (res > 66'sd2147483647) begin
                res = 66'sd2147483647;
                r.saturated = 1'b1;
            end else if (res < -66'sd2147483648) begin
                res = -66'sd2147483648;
                r.saturated = 1'b1;
            end
            r.pt[i] = res[31:0];
        end
        return r;
    endfunction

    function automatic coord_t rand_extreme();
        case ($urandom_range(6))
            0: return CMIN;
            1: return CMAX;
            2: return 0;
            3: return -1;
            4: return 1;
            5: return CMIN + 1;
            default: return CMAX - 1;
        endcase
    endfunction

    // mix of full-range, small fractional, whole-number and extreme values
    function automatic coord_t rand_coord();
        coord_t v;
        int     pick;
        pick = $urandom_range(99);
        if (pick < 40) begin
            v = $urandom;
        end else if (pick < 70) begin
            v = $urandom_range(0, 16 * 65536);
            v = v - 8 * 65536;
        end else if (pick < 85) begin
            v = $urandom_range(0, 200);
            v = (v - 100) <<< FRAC_BITS;
        end else begin
            v = rand_extreme();
        end
        return v;
    endfunction

    function automatic plane_t random_plane(input plane_kind_e kind);
        plane_t pl;
        int     axis;
        pl = '0;
        case (kind)
            PLANE_AXIS: begin
                axis = $urandom_range(2);
                pl.coef[axis] = $urandom_range(1, 1 << 20);
                if ($urandom_range(1))
                    pl.coef[axis] = -pl.coef[axis];
                pl.offset = $urandom_range(0, 64 * 65536);
                pl.offset = pl.offset - 32 * 65536;
            end
            PLANE_SMALL: begin
                for (int i = 0; i < 3; i++) begin
                    pl.coef[i] = $urandom_range(0, 8 * 65536);
                    pl.coef[i] = pl.coef[i] - 4 * 65536;
                end
                pl.offset = rand_coord();
            end
            PLANE_FULL: begin
                for (int i = 0; i < 3; i++)
                    pl.coef[i] = $urandom;
                pl.offset = $urandom;
            end
            PLANE_EXTREME: begin
                for (int i = 0; i < 3; i++)
                    pl.coef[i] = rand_extreme();
                pl.offset = rand_extreme();
            end
            PLANE_DEGENERATE: begin
                pl.offset = $urandom;
            end
            default: begin
                // tiny normal: huge quotients, mostly clamped
                for (int i = 0; i < 3; i++) begin
                    pl.coef[i] = $urandom_range(0, 30);
                    pl.coef[i] = pl.coef[i] - 15;
                end
                pl.offset = rand_coord();
            end
        endcase
        return pl;
    endfunction

    // leaves cfg_valid high so back-to-back writes need no gap
    task automatic write_plane_reg(input reg_idx_t idx, input coord_t value);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_PLANE_A:      model_plane.coef[0] = value;
            REG_PLANE_B:      model_plane.coef[1] = value;
            REG_PLANE_C:      model_plane.coef[2] = value;
            REG_PLANE_OFFSET: model_plane.offset  = value;
        endcase
    endtask

    task automatic program_plane(input plane_t pl);
        write_plane_reg(REG_PLANE_A, pl.coef[0]);
        write_plane_reg(REG_PLANE_B, pl.coef[1]);
        write_plane_reg(REG_PLANE_C, pl.coef[2]);
        write_plane_reg(REG_PLANE_OFFSET, pl.offset);
        cfg_valid <= 1'b0;
    endtask

    // one point transfer; s_tvalid stays high afterwards for a back-to-back item
    task automatic send_point(input vec3_t pt, input bit typed, input reflection_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pt;
        do @(posedge aclk); while (!s_tready);
        pending_mirrors.push_back(typed ? want : reflect_point(model_plane, pt));
    endtask

    // wait for every queued result, sender quiet
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_mirrors.size() != 0)
            @(posedge aclk);
    endtask

    // receiver back-pressure
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // result checker: each output transfer against the oldest expectation
    always @(posedge aclk) begin
        reflection_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_mirrors.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got data %h user %b",
                         $time, m_tdata, m_tuser);
            end else begin
                want = pending_mirrors.pop_front();
                for (int i = 0; i < 3; i++) begin
                    if (m_tdata[COORD_W*i +: COORD_W] !== want.pt[i]) begin
                        mismatches++;
                        $display("%0t: mirror axis %0d expected %0d, got %0d", $time, i,
                                 $signed(want.pt[i]), $signed(m_tdata[COORD_W*i +: COORD_W]));
                    end
                end
                if (m_tuser[TUSER_BAD] !== want.bad_plane) begin
                    mismatches++;
                    $display("%0t: bad_plane expected %b, got %b",
                             $time, want.bad_plane, m_tuser[TUSER_BAD]);
                end
                if (m_tuser[TUSER_SAT] !== want.saturated) begin
                    mismatches++;
                    $display("%0t: saturated expected %b, got %b",
                             $time, want.saturated, m_tuser[TUSER_SAT]);
                end
            end
        end
    end

    initial begin
        reflection_t want;
        vec3_t       pt;
        plane_t      pl;
        model_plane = '0;
        model_plane.coef[0] = A_RESET;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows, no idling
        for (int i = 0; i < NUM_ROWS; i++) begin
            if (dir_rows[i].kind == ROW_WRITE) begin
                drain_results();
                write_plane_reg(dir_rows[i].reg_sel, dir_rows[i].x);
                if (i == NUM_ROWS - 1 || dir_rows[i + 1].kind != ROW_WRITE)
                    cfg_valid <= 1'b0;
            end else begin
                want.pt        = {dir_rows[i].ez, dir_rows[i].ey, dir_rows[i].ex};
                want.bad_plane = dir_rows[i].ebad;
                want.saturated = dir_rows[i].esat;
                send_point({dir_rows[i].z, dir_rows[i].y, dir_rows[i].x},
                           dir_rows[i].typed, want);
            end
        end

        // random phases: fresh plane each time, idling pattern rotates
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            pl = random_plane(plane_kind_e'(ph % 6));
            program_plane(pl);
            case (idle_mode_e'(ph % 4))
                IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                IDLE_SENDER:   begin send_idle_pct = 67; recv_stall_pct = 0;  end
                IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                IDLE_BOTH:     begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            for (int n = 0; n < PHASE_PTS; n++) begin
                for (int i = 0; i < 3; i++)
                    pt[i] = rand_coord();
                send_point(pt, 1'b0, '0);
            end
        end

        // let the pipeline empty, then watch for stray results
        drain_results();
        repeat (PIPE_DEPTH + 8) @(posedge aclk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/ppr_pkg.sv
sv/ppr_dot.sv
sv/ppr_scale.sv
sv/ppr_div.sv
sv/ppr_out.sv
sv/point_plane_reflection.sv
sv/ppr_chk.sv
tb/tb_point_plane_reflection.sv
